FILE: sv/isb_pkg.sv
package isb_pkg;

  localparam int WindowSlots = 64;
  localparam int ArchRegs    = 64;
  localparam int MaxSources  = 3;
  localparam int MaxDests    = 2;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam logic KIND_DEP     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

FILE: sv/instruction_dependency_scoreboard.sv
// Dependency scoreboard over a window of WINDOW_SLOTS instruction slots (slot = id modulo
// WINDOW_SLOTS). One item is handled at a time; s_tready is high only between items. Every
// item first reduces its id to a slot (reciprocal multiply, then subtract) and reads the
// slot owner. A register op that takes a new slot evicts it by clearing its edge row and
// column. It then checks each source for a live producer, writing an edge and emitting a
// beat through the output handshake per dependency found, searches the store addresses one
// memory entry at a time, records its destinations and finishes with the summary. A release
// sweeps its edge row slot by slot, then finishes. A query returns the slot's pending count
// in its summary. Reset and a clear op run a clearing pass over the edge memory, during
// which no item is taken. Results leave through an output register, one beat per result,
// m_tlast on the summary beat of each item.
module instruction_dependency_scoreboard #(
  parameter int WINDOW_SLOTS = isb_pkg::WindowSlots,
  parameter int ARCH_REGS    = isb_pkg::ArchRegs,
  parameter int MAX_SOURCES  = isb_pkg::MaxSources,
  parameter int MAX_DESTS    = isb_pkg::MaxDests
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // instr_id[31:0] src_reg_0[37:32] src_reg_1[43:38] src_reg_2[49:44]
  // src_valid_mask[52:50] dst_reg_0[58:53] dst_reg_1[64:59] dst_valid_mask[66:65]
  // has_mem[67] is_load[68] mem_addr[132:69], zero fill above
  input  logic [135:0] s_tdata,
  // op[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // producer[31:0] is_memory[32] pending[35:33] ready_res[36], zero fill above
  output logic [39:0]  m_tdata,
  // kind[0]
  output logic         m_tuser,
  output logic         m_tlast
);

  localparam int SW = $clog2(WINDOW_SLOTS);
  localparam int RW = $clog2(ARCH_REGS);
  localparam int EW = $clog2(WINDOW_SLOTS * WINDOW_SLOTS);
  localparam int CW = EW + 1;
  localparam int NS = (MAX_SOURCES < 3) ? MAX_SOURCES : 3;
  localparam int ND = (MAX_DESTS < 2) ? MAX_DESTS : 2;
  localparam int QSH = 32 + SW;
  localparam logic [32:0] RECIP = 33'((64'd1 << QSH) / 64'(WINDOW_SLOTS) + 64'd1);

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_MOD   = 5'd2;
  localparam logic [4:0] S_DISP  = 5'd3;
  localparam logic [4:0] S_OWN   = 5'd4;
  localparam logic [4:0] S_EVICT = 5'd5;
  localparam logic [4:0] S_SRC   = 5'd6;
  localparam logic [4:0] S_SRCW  = 5'd7;
  localparam logic [4:0] S_SRCC  = 5'd8;
  localparam logic [4:0] S_EDGEW = 5'd9;
  localparam logic [4:0] S_EMIT  = 5'd10;
  localparam logic [4:0] S_MEM   = 5'd11;
  localparam logic [4:0] S_MSCAN = 5'd12;
  localparam logic [4:0] S_MCHK  = 5'd13;
  localparam logic [4:0] S_DST   = 5'd14;
  localparam logic [4:0] S_STORE = 5'd15;
  localparam logic [4:0] S_SUM   = 5'd16;
  localparam logic [4:0] S_RRD   = 5'd17;
  localparam logic [4:0] S_RWR   = 5'd18;
  localparam logic [4:0] S_RFIN  = 5'd19;
  localparam logic [4:0] S_SLOT  = 5'd20;

  logic [4:0] state;
  logic [4:0] ret_state;

  // latched item
  logic [1:0]  op;
  logic [31:0] id;
  logic [5:0]  srcs [3];
  logic [2:0]  smask;
  logic [5:0]  dsts [2];
  logic [1:0]  dmask;
  logic        has_mem;
  logic        is_load;
  logic [63:0] addr;

  logic [SW-1:0] slot;
  logic [31:0]   quo;
  logic [CW-1:0] cnt;
  logic [1:0]    si;
  logic [1:0]    di;
  logic [2:0]    count;
  logic [31:0]   pid;
  logic [SW-1:0] pslot;
  logic          dep_mem;
  logic [EW-1:0] ea;
  logic          found;
  logic [SW-1:0] mslot;
  logic [2:0]    sum_val;
  logic          clr_sum;

  // flop state
  logic [WINDOW_SLOTS-1:0] slot_valid;
  logic [WINDOW_SLOTS-1:0] slot_completed;
  logic [WINDOW_SLOTS-1:0] store_latest;
  logic [ARCH_REGS-1:0]    reg_producer_valid;

  // memories
  logic [31:0]    owner_mem [WINDOW_SLOTS];
  logic [SW+31:0] rp_mem    [ARCH_REGS];
  logic [63:0]    st_mem    [WINDOW_SLOTS];
  logic [2:0]     edge_mem  [WINDOW_SLOTS * WINDOW_SLOTS];
  logic [2:0]     pend_mem  [WINDOW_SLOTS];

  logic           own_we;
  logic [SW-1:0]  own_wa, own_ra;
  logic [31:0]    own_wd, own_rd;
  logic           rp_we;
  logic [RW-1:0]  rp_wa, rp_ra;
  logic [SW+31:0] rp_wd, rp_rd;
  logic           st_we;
  logic [SW-1:0]  st_wa, st_ra;
  logic [63:0]    st_wd, st_rd;
  logic           e_we;
  logic [EW-1:0]  e_wa, e_ra;
  logic [2:0]     e_wd, e_rd;
  logic           pend_we;
  logic [SW-1:0]  pend_wa, pend_ra;
  logic [2:0]     pend_wd, pend_rd;

  logic [64:0]   recip_prod;
  logic [SW-1:0] cslot;
  logic [5:0]    cur_src, cur_dst;
  logic          src_ok, dst_ok;
  logic          owns;
  logic          src_live;
  logic          m_match, m_live;
  logic          out_free;
  logic [2:0]    sub_val;

  function automatic logic [EW-1:0] ea_of(input logic [SW-1:0] p, input logic [SW-1:0] c);
    ea_of = EW'(int'(p) * WINDOW_SLOTS + int'(c));
  endfunction

  always_ff @(posedge clk) begin
    if (own_we) owner_mem[own_wa] <= own_wd;
    own_rd <= owner_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (rp_we) rp_mem[rp_wa] <= rp_wd;
    rp_rd <= rp_mem[rp_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_rd <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_wa] <= e_wd;
    e_rd <= edge_mem[e_ra];
  end

  // only read behind slot_valid; written by a register op after its slot turns valid
  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_rd <= pend_mem[pend_ra];
  end

  assign recip_prod = {33'd0, id} * {32'd0, RECIP};
  assign cslot    = cnt[SW-1:0];
  assign cur_src  = srcs[si];
  assign cur_dst  = dsts[di[0]];
  assign src_ok   = smask[si] && (int'(cur_src) < ARCH_REGS) &&
                    reg_producer_valid[RW'(cur_src)];
  assign dst_ok   = dmask[di[0]] && (int'(cur_dst) < ARCH_REGS);
  assign owns     = slot_valid[slot] && (own_rd == id);
  assign src_live = (pid != id) && slot_valid[pslot] && (own_rd == pid) &&
                    !slot_completed[pslot];
  assign m_match  = store_latest[cslot] && (st_rd == addr);
  assign m_live   = (own_rd != id) && slot_valid[cslot] && !slot_completed[cslot];
  assign out_free = !m_tvalid || m_tready;
  assign sub_val  = (pend_rd > e_rd) ? pend_rd - e_rd : 3'd0;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    own_we = 1'b0; own_wa = slot; own_wd = id; own_ra = slot;
    rp_we  = 1'b0; rp_wa = RW'(cur_dst); rp_wd = {id, slot}; rp_ra = RW'(cur_src);
    st_we  = 1'b0; st_wa = slot; st_wd = addr; st_ra = cslot;
    e_we   = 1'b0; e_wa = ea; e_wd = 3'd0; e_ra = ea;
    pend_we = 1'b0; pend_wa = slot; pend_wd = count; pend_ra = slot;
    case (state)
      S_INIT: begin
        e_we = 1'b1;
        e_wa = cnt[EW-1:0];
      end
      S_OWN: begin
        if (op == isb_pkg::OP_REGISTER && !owns) own_we = 1'b1;
      end
      S_EVICT: begin
        e_we = 1'b1;
        e_wa = (int'(cnt) < WINDOW_SLOTS) ? ea_of(slot, cslot) :
               ea_of(SW'(int'(cnt) - WINDOW_SLOTS), slot);
      end
      S_SRCW: own_ra = rp_rd[SW-1:0];
      S_SRCC: e_ra = ea_of(pslot, slot);
      S_EDGEW: begin
        e_we = 1'b1;
        e_wd = (e_rd == 3'd7) ? 3'd7 : e_rd + 3'd1;
      end
      S_MSCAN: own_ra = cslot;
      S_MCHK: e_ra = ea_of(cslot, slot);
      S_DST: rp_we = (int'(di) < ND) && dst_ok;
      S_STORE: begin
        st_we   = has_mem && !is_load;
        pend_we = 1'b1;
      end
      S_RRD: begin
        e_ra    = ea_of(slot, cslot);
        pend_ra = cslot;
      end
      S_RWR: begin
        e_we    = 1'b1;
        e_wa    = ea_of(slot, cslot);
        pend_we = (e_rd != 3'd0) && slot_valid[cslot];
        pend_wa = cslot;
        pend_wd = sub_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_INIT;
      cnt                <= '0;
      clr_sum            <= 1'b0;
      m_tvalid           <= 1'b0;
      slot_valid         <= '0;
      slot_completed     <= '0;
      store_latest       <= '0;
      reg_producer_valid <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT && state != S_SUM) m_tvalid <= 1'b0;
      case (state)
        S_INIT: begin
          if (int'(cnt) == WINDOW_SLOTS * WINDOW_SLOTS - 1) begin
            cnt     <= '0;
            sum_val <= 3'd0;
            state   <= clr_sum ? S_SUM : S_IDLE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= s_tuser;
            id      <= s_tdata[31:0];
            srcs[0] <= s_tdata[37:32];
            srcs[1] <= s_tdata[43:38];
            srcs[2] <= s_tdata[49:44];
            smask   <= s_tdata[52:50];
            dsts[0] <= s_tdata[58:53];
            dsts[1] <= s_tdata[64:59];
            dmask   <= s_tdata[66:65];
            has_mem <= s_tdata[67];
            is_load <= s_tdata[68];
            addr    <= s_tdata[132:69];
            state   <= S_MOD;
          end
        end
        S_MOD: begin
          quo   <= 32'(recip_prod >> QSH);
          state <= S_SLOT;
        end
        S_SLOT: begin
          slot  <= SW'(id - quo * 32'(WINDOW_SLOTS));
          state <= S_DISP;
        end
        S_DISP: state <= S_OWN;
        S_OWN: begin
          count <= 3'd0;
          found <= 1'b0;
          si    <= '0;
          di    <= '0;
          cnt   <= '0;
          case (op)
            isb_pkg::OP_REGISTER: begin
              if (!owns) begin
                slot_valid[slot]     <= 1'b1;
                slot_completed[slot] <= 1'b0;
                store_latest[slot]   <= 1'b0;
                state                <= S_EVICT;
              end else begin
                state <= S_SRC;
              end
            end
            isb_pkg::OP_RELEASE: begin
              if (owns) begin
                slot_completed[slot] <= 1'b1;
                sum_val              <= pend_rd;
                state                <= S_RRD;
              end else begin
                sum_val <= 3'd0;
                state   <= S_SUM;
              end
            end
            isb_pkg::OP_QUERY: begin
              sum_val <= owns ? pend_rd : 3'd0;
              state   <= S_SUM;
            end
            default: begin
              slot_valid         <= '0;
              slot_completed     <= '0;
              store_latest       <= '0;
              reg_producer_valid <= '0;
              clr_sum <= 1'b1;
              state   <= S_INIT;
            end
          endcase
        end
        S_EVICT: begin
          if (int'(cnt) == 2 * WINDOW_SLOTS - 1) begin
            cnt   <= '0;
            state <= S_SRC;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_SRC: begin
          if (int'(si) >= NS) state <= S_MEM;
          else if (src_ok) state <= S_SRCW;
          else si <= si + 2'd1;
        end
        S_SRCW: begin
          pid   <= rp_rd[SW+31:SW];
          pslot <= rp_rd[SW-1:0];
          state <= S_SRCC;
        end
        S_SRCC: begin
          si <= si + 2'd1;
          if (src_live) begin
            ea        <= ea_of(pslot, slot);
            dep_mem   <= 1'b0;
            ret_state <= S_SRC;
            state     <= S_EDGEW;
          end else begin
            state <= S_SRC;
          end
        end
        S_EDGEW: begin
          count <= count + 3'd1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid         <= 1'b1;
            m_tuser          <= isb_pkg::KIND_DEP;
            m_tlast          <= 1'b0;
            m_tdata          <= {3'd0, 1'b0, 3'd0, dep_mem, pid};
            state            <= ret_state;
          end
        end
        S_MEM: begin
          cnt   <= '0;
          state <= has_mem ? S_MSCAN : S_DST;
        end
        S_MSCAN: state <= S_MCHK;
        S_MCHK: begin
          if (m_match) begin
            found <= 1'b1;
            mslot <= cslot;
            if (m_live) begin
              pid       <= own_rd;
              ea        <= ea_of(cslot, slot);
              dep_mem   <= 1'b1;
              ret_state <= S_DST;
              state     <= S_EDGEW;
            end else begin
              state <= S_DST;
            end
          end else if (int'(cnt) == WINDOW_SLOTS - 1) begin
            state <= S_DST;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_MSCAN;
          end
        end
        S_DST: begin
          if (int'(di) >= ND) begin
            state <= S_STORE;
          end else begin
            if (dst_ok) reg_producer_valid[RW'(cur_dst)] <= 1'b1;
            di <= di + 2'd1;
          end
        end
        S_STORE: begin
          if (has_mem && !is_load) begin
            if (found) store_latest[mslot] <= 1'b0;
            store_latest[slot] <= 1'b1;
          end
          sum_val <= count;
          state   <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= isb_pkg::KIND_SUMMARY;
            m_tlast  <= 1'b1;
            m_tdata  <= {3'd0, (sum_val == 3'd0), sum_val, 1'b0, 32'd0};
            clr_sum  <= 1'b0;
            state    <= S_IDLE;
          end
        end
        S_RRD: state <= S_RWR;
        S_RWR: begin
          // drop the consumer's count by the edge weight, floor at zero
          if (e_rd != 3'd0 && cslot == slot) sum_val <= sub_val;
          if (int'(cnt) == WINDOW_SLOTS - 1) begin
            state <= S_RFIN;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_RRD;
          end
        end
        S_RFIN: state <= S_SUM;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
